### hdl/pdf_pkg.sv
`timescale 1ns / 1ps
// Package for the length-prefixed frame decoder with CRC-16/XMODEM.
// Holds the shared types, frame constants and the CRC byte update.
// No dependencies.
package pdf_pkg;

  // Store geometry and length limit
  localparam int unsigned StoreDepth = 512;
  localparam int unsigned StoreAw    = 9;
  localparam int unsigned CntW       = 10;
  localparam logic [15:0] LenLimit   = 16'd512;

  // Frame bytes
  localparam logic [7:0] SOF_SHORT = 8'h02;
  localparam logic [7:0] SOF_LONG  = 8'h03;
  localparam logic [7:0] EOF_BYTE  = 8'h03;

  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  // Operation carried by one queued transaction
  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } pdf_op_t;

  typedef struct packed {
    pdf_op_t           op;
    logic [7:0]        data;
    logic [StoreAw-1:0] idx;
  } pdf_item_t;

  // Parser phases, one-hot
  typedef enum logic [6:0] {
    PH_START   = 7'b0000001,
    PH_LEN_HI  = 7'b0000010,
    PH_LEN_LO  = 7'b0000100,
    PH_PAYLOAD = 7'b0001000,
    PH_CRC_HI  = 7'b0010000,
    PH_CRC_LO  = 7'b0100000,
    PH_END     = 7'b1000000
  } pdf_phase_t;

  // Advance the CRC-16/XMODEM by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/pdf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/pdf_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them and queues them.
// Depends on pdf_pkg.
module pdf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [7:0]                 in_rx_byte,
  input  logic [pdf_pkg::StoreAw-1:0] in_read_index,
  output logic                       q_valid,
  output pdf_pkg::pdf_item_t         q_item,
  input  logic                       q_pop
);
  import pdf_pkg::*;

  pdf_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  pdf_item_t  item_in;

  // Classify the incoming transaction
  always_comb begin
    item_in.op   = in_func ? OP_READ : OP_FEED;
    item_in.data = in_rx_byte;
    item_in.idx  = in_read_index;
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue fill count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && count_r == 2'd0 |=> count_r == 2'd1)
    else $error("queue count did not follow a push into an empty queue");
`endif

endmodule

### hdl/pdf_back.sv
`timescale 1ns / 1ps
// Back end: frame parser, CRC check, error counters, payload store, output register.
// Depends on pdf_pkg and pdf_ram.
module pdf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  pdf_pkg::pdf_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_packet_ok,
  output logic                        out_crc_error,
  output logic                        out_framing_error,
  output logic [pdf_pkg::CntW-1:0]    out_payload_length,
  output logic [31:0]                 out_crc_error_total,
  output logic [31:0]                 out_framing_error_total,
  output logic [7:0]                  out_read_data
);
  import pdf_pkg::*;

  pdf_phase_t         phase_r, phase_nxt;
  logic [15:0]        exp_len_r, exp_len_nxt;
  logic [CntW-1:0]    count_r, count_nxt;
  logic [15:0]        rx_crc_r, rx_crc_nxt;
  logic [15:0]        run_crc_r, run_crc_nxt;
  logic [31:0]        crc_tot_r, crc_tot_nxt;
  logic [31:0]        frm_tot_r, frm_tot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               ok_r, ok_nxt;
  logic               crc_bad_r, crc_bad_nxt;
  logic               frm_bad_r, frm_bad_nxt;
  logic               rd_flag_r, rd_flag_nxt;
  logic               advance;
  logic               mem_we;
  logic               mem_re;
  logic [7:0]         mem_q;
  logic [15:0]        len_full;

  assign advance = !out_valid_r || out_ready;
  assign q_pop   = q_valid && advance;
  assign mem_re  = q_pop && (q_item.op == OP_READ);
  assign len_full = exp_len_r | {8'h00, q_item.data};

  // Parse one transaction per cycle while the output register can advance
  always_comb begin
    phase_nxt    = phase_r;
    exp_len_nxt  = exp_len_r;
    count_nxt    = count_r;
    rx_crc_nxt   = rx_crc_r;
    run_crc_nxt  = run_crc_r;
    crc_tot_nxt  = crc_tot_r;
    frm_tot_nxt  = frm_tot_r;
    ok_nxt       = 1'b0;
    crc_bad_nxt  = 1'b0;
    frm_bad_nxt  = 1'b0;
    mem_we       = 1'b0;
    if (q_pop && q_item.op == OP_FEED) begin
      unique case (phase_r)
        PH_LEN_HI: begin
          exp_len_nxt = {q_item.data, 8'h00};
          phase_nxt   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          exp_len_nxt = len_full;
          if (len_full == 16'd0 || len_full > LenLimit) begin
            frm_bad_nxt = 1'b1;
            frm_tot_nxt = (frm_tot_r == CountMax) ? frm_tot_r : frm_tot_r + 32'd1;
            phase_nxt   = PH_START;
          end else begin
            count_nxt   = '0;
            run_crc_nxt = 16'h0000;
            phase_nxt   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          mem_we      = 1'b1;
          run_crc_nxt = crc_byte(run_crc_r, q_item.data);
          count_nxt   = count_r + {{(CntW-1){1'b0}}, 1'b1};
          if ({{(16-CntW){1'b0}}, count_nxt} >= exp_len_r) begin
            phase_nxt = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          rx_crc_nxt = {q_item.data, 8'h00};
          phase_nxt  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc_nxt = rx_crc_r | {8'h00, q_item.data};
          phase_nxt  = PH_END;
        end
        PH_END: begin
          phase_nxt = PH_START;
          if (q_item.data != EOF_BYTE) begin
            frm_bad_nxt = 1'b1;
            frm_tot_nxt = (frm_tot_r == CountMax) ? frm_tot_r : frm_tot_r + 32'd1;
          end else if (run_crc_r != rx_crc_r) begin
            crc_bad_nxt = 1'b1;
            crc_tot_nxt = (crc_tot_r == CountMax) ? crc_tot_r : crc_tot_r + 32'd1;
          end else begin
            ok_nxt = 1'b1;
          end
        end
        default: begin
          // Waiting for a start byte; unknown phase codes land here too
          if (q_item.data == SOF_SHORT) begin
            exp_len_nxt = 16'd0;
            phase_nxt   = PH_LEN_LO;
          end else if (q_item.data == SOF_LONG) begin
            exp_len_nxt = 16'd0;
            phase_nxt   = PH_LEN_HI;
          end else begin
            phase_nxt = PH_START;
          end
        end
      endcase
    end
  end

  // Load the output register on every advance
  always_comb begin
    out_valid_nxt = out_valid_r;
    rd_flag_nxt   = rd_flag_r;
    if (advance) begin
      out_valid_nxt = q_valid;
      rd_flag_nxt   = mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      exp_len_r   <= 16'd0;
      count_r     <= '0;
      rx_crc_r    <= 16'd0;
      run_crc_r   <= 16'd0;
      crc_tot_r   <= 32'd0;
      frm_tot_r   <= 32'd0;
      out_valid_r <= 1'b0;
      rd_flag_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      exp_len_r   <= exp_len_nxt;
      count_r     <= count_nxt;
      rx_crc_r    <= rx_crc_nxt;
      run_crc_r   <= run_crc_nxt;
      crc_tot_r   <= crc_tot_nxt;
      frm_tot_r   <= frm_tot_nxt;
      out_valid_r <= out_valid_nxt;
      rd_flag_r   <= rd_flag_nxt;
    end
  end

  // Result flags, hold while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      ok_r      <= ok_nxt;
      crc_bad_r <= crc_bad_nxt;
      frm_bad_r <= frm_bad_nxt;
    end
  end

  pdf_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[StoreAw-1:0]),
    .wdata (q_item.data),
    .re    (mem_re),
    .raddr (q_item.idx),
    .rdata (mem_q)
  );

  // State only moves on an advance, so the live registers match the held result
  assign out_valid               = out_valid_r;
  assign out_packet_ok           = ok_r;
  assign out_crc_error           = crc_bad_r;
  assign out_framing_error       = frm_bad_r;
  assign out_payload_length      = count_r;
  assign out_crc_error_total     = crc_tot_r;
  assign out_framing_error_total = frm_tot_r;
  assign out_read_data           = rd_flag_r ? mem_q : 8'h00;

`ifndef SYNTHESIS
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({ok_r, crc_bad_r, frm_bad_r}))
    else $error("more than one frame outcome flagged");

  a_read_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rd_flag_r |-> !ok_r && !crc_bad_r && !frm_bad_r)
    else $error("read transaction carries a frame flag");

  a_crc_tot_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> crc_tot_r >= $past(crc_tot_r))
    else $error("CRC error total decreased");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {{(16-CntW){1'b0}}, count_r} <= LenLimit)
    else $error("payload count beyond length limit");
`endif

endmodule

### hdl/packet_deframer_crc16.sv
`timescale 1ns / 1ps
// Top level of the length-prefixed frame decoder with CRC-16/XMODEM.
// Depends on pdf_pkg, pdf_front and pdf_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | func, rx_byte, read_index
//  out      | out_valid / out_ready| packet_ok, crc_error, framing_error,
//           |                      | payload_length, crc/framing_error_total,
//           |                      | read_data
//
// One transaction per cycle sustained while the output is not stalled; a result passes
// through the two-entry input queue and then the parser/output register before it is offered.
// The payload store read port sets the output stage: read data is registered.
// Synchronous active-low reset clears parser, counters and queue; no store clear.
// An output stall fills the queue and then drops in_ready; no transaction is lost.
module packet_deframer_crc16 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [7:0]                  in_rx_byte,
  input  logic [8:0]                  in_read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_packet_ok,
  output logic                        out_crc_error,
  output logic                        out_framing_error,
  output logic [9:0]                  out_payload_length,
  output logic [31:0]                 out_crc_error_total,
  output logic [31:0]                 out_framing_error_total,
  output logic [7:0]                  out_read_data
);
  import pdf_pkg::*;

  logic      q_valid;
  pdf_item_t q_item;
  logic      q_pop;

  pdf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_rx_byte    (in_rx_byte),
    .in_read_index (in_read_index),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  pdf_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_valid                 (q_valid),
    .q_item                  (q_item),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_packet_ok           (out_packet_ok),
    .out_crc_error           (out_crc_error),
    .out_framing_error       (out_framing_error),
    .out_payload_length      (out_payload_length),
    .out_crc_error_total     (out_crc_error_total),
    .out_framing_error_total (out_framing_error_total),
    .out_read_data           (out_read_data)
  );

endmodule
